>>> sv/chm_pkg.sv
// Shared types, codes and defaults for the chained hash map.
package chm_pkg;

    localparam int BUCKET_BITS_DEF  = 8;
    localparam int POOL_ENTRIES_DEF = 64;
    localparam int KEY_HASH_BITS    = 20;
    localparam int HASH_SHIFT       = 11;

    // register byte addresses
    localparam logic [1:0] ADDR_NOT_FOUND = 2'd0;

    // request operation codes
    typedef enum logic [1:0] {
        OP_LOOKUP = 2'd0,
        OP_ADD    = 2'd1,
        OP_REMOVE = 2'd2,
        OP_NONE   = 2'd3
    } op_t;

    // result status codes
    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_ABSENT = 2'd1,
        ST_DUP    = 2'd2,
        ST_FULL   = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_HEAD,
        S_PROBE,
        S_DECIDE,
        S_LINK,
        S_OUT
    } state_t;

    typedef struct packed {
        logic [1:0]  operation;
        logic [31:0] key;
        logic [31:0] value;
    } req_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] read_value;
    } rsp_t;

    // controller to datapath
    typedef struct packed {
        logic    accept;
        logic    clear_step;
        logic    take_head;
        logic    probe_next;
        logic    record_found;
        logic    add_write;
        logic    add_link;
        logic    rem_write;
        logic    set_result;
        status_t status_code;
        logic    use_val;
        logic    load_out;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic [1:0] operation;
        logic       head_nil;
        logic       head_was_nil;
        logic       key_hit;
        logic       next_nil;
        logic       found;
        logic       pool_empty;
        logic       out_free;
        logic       clear_done;
    } sts_t;

endpackage

>>> sv/chained_hash_map_int_key.sv
// Chained hash map top level: APB register, controller and datapath.
// Each item is accepted, its bucket head read, its chain walked entry by entry until a key hit
// or the chain end, the result decided, a link written for a successful add into a non-empty
// bucket, then the result handed to the output register.
// One item at a time: a new request is taken only after the last result is handed over.
// Reset: bucket table cleared in one pass over all 2^BUCKET_BITS buckets, free pool full,
// not-found value 0.
module chained_hash_map_int_key
#(
    parameter int BUCKET_BITS  = chm_pkg::BUCKET_BITS_DEF,
    parameter int POOL_ENTRIES = chm_pkg::POOL_ENTRIES_DEF
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_ready,
    input  chm_pkg::req_t req_data,
    output logic          rsp_valid,
    input  logic          rsp_ready,
    output chm_pkg::rsp_t rsp_data,
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [1:0]    paddr,
    input  logic [31:0]   pwdata,
    output logic [31:0]   prdata,
    output logic          pready
);

    logic [31:0]   nf_reg;
    chm_pkg::cmd_t cmd;
    chm_pkg::sts_t sts;

    // configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nf_reg <= '0;
        end
        else if (psel && penable && pwrite && (paddr == chm_pkg::ADDR_NOT_FOUND))
        begin
            nf_reg <= pwdata;
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr == chm_pkg::ADDR_NOT_FOUND) ? nf_reg : 32'd0;

    chm_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    chm_datapath
    #(
        .BUCKET_BITS  (BUCKET_BITS),
        .POOL_ENTRIES (POOL_ENTRIES)
    )
    u_datapath
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .req_data        (req_data),
        .not_found_value (nf_reg),
        .cmd             (cmd),
        .sts             (sts),
        .rsp_ready       (rsp_ready),
        .rsp_valid       (rsp_valid),
        .rsp_data        (rsp_data)
    );

endmodule

>>> sv/chm_ctrl.sv
// Controller state machine for the chained hash map.
module chm_ctrl
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_ready,
    input  chm_pkg::sts_t sts,
    output chm_pkg::cmd_t cmd
);

    chm_pkg::state_t state_reg;
    chm_pkg::state_t state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= chm_pkg::S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state and commands
    always_comb
    begin
        state_next      = state_reg;
        cmd             = '0;
        cmd.status_code = chm_pkg::ST_ABSENT;
        req_ready       = 1'b0;
        unique case (state_reg)
            chm_pkg::S_CLEAR:
            begin
                cmd.clear_step = 1'b1;
                if (sts.clear_done)
                begin
                    state_next = chm_pkg::S_IDLE;
                end
            end
            chm_pkg::S_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = chm_pkg::S_HEAD;
                end
            end
            chm_pkg::S_HEAD:
            begin
                cmd.take_head = 1'b1;
                state_next = sts.head_nil ? chm_pkg::S_DECIDE : chm_pkg::S_PROBE;
            end
            chm_pkg::S_PROBE:
            begin
                if (sts.key_hit)
                begin
                    cmd.record_found = 1'b1;
                    state_next = chm_pkg::S_DECIDE;
                end
                else if (sts.next_nil)
                begin
                    state_next = chm_pkg::S_DECIDE;
                end
                else
                begin
                    cmd.probe_next = 1'b1;
                end
            end
            chm_pkg::S_DECIDE:
            begin
                cmd.set_result = 1'b1;
                state_next = chm_pkg::S_OUT;
                case (sts.operation)
                    chm_pkg::OP_LOOKUP:
                    begin
                        if (sts.found)
                        begin
                            cmd.status_code = chm_pkg::ST_OK;
                            cmd.use_val     = 1'b1;
                        end
                    end
                    chm_pkg::OP_ADD:
                    begin
                        if (sts.found)
                        begin
                            cmd.status_code = chm_pkg::ST_DUP;
                        end
                        else if (sts.pool_empty)
                        begin
                            cmd.status_code = chm_pkg::ST_FULL;
                        end
                        else
                        begin
                            cmd.status_code = chm_pkg::ST_OK;
                            cmd.add_write   = 1'b1;
                            if (!sts.head_was_nil)
                            begin
                                state_next = chm_pkg::S_LINK;
                            end
                        end
                    end
                    chm_pkg::OP_REMOVE:
                    begin
                        if (sts.found)
                        begin
                            cmd.status_code = chm_pkg::ST_OK;
                            cmd.rem_write   = 1'b1;
                        end
                    end
                    default:
                    begin
                        cmd.status_code = chm_pkg::ST_ABSENT;
                    end
                endcase
            end
            chm_pkg::S_LINK:
            begin
                cmd.add_link = 1'b1;
                state_next = chm_pkg::S_OUT;
            end
            chm_pkg::S_OUT:
            begin
                if (sts.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next = chm_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = chm_pkg::S_IDLE;
            end
        endcase
    end

endmodule

>>> sv/chm_datapath.sv
// Datapath of the chained hash map: tables, entry pool, free list, result.
module chm_datapath
#(
    parameter int BUCKET_BITS  = chm_pkg::BUCKET_BITS_DEF,
    parameter int POOL_ENTRIES = chm_pkg::POOL_ENTRIES_DEF
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  chm_pkg::req_t req_data,
    input  logic [31:0]   not_found_value,
    input  chm_pkg::cmd_t cmd,
    output chm_pkg::sts_t sts,
    input  logic          rsp_ready,
    output logic          rsp_valid,
    output chm_pkg::rsp_t rsp_data
);

    localparam int BUCKETS = 1 << BUCKET_BITS;
    localparam int PW      = $clog2(POOL_ENTRIES + 1);
    localparam int IW      = $clog2(POOL_ENTRIES);
    localparam logic [PW-1:0] NIL      = PW'(POOL_ENTRIES);
    localparam logic [IW-1:0] LAST_IDX = IW'(POOL_ENTRIES - 1);

    // memories
    logic [PW-1:0] head_mem [BUCKETS];
    logic [31:0]   key_mem  [POOL_ENTRIES];
    logic [31:0]   val_mem  [POOL_ENTRIES];
    logic [PW-1:0] next_mem [POOL_ENTRIES];
    logic [PW-1:0] prev_mem [POOL_ENTRIES];
    logic [IW-1:0] fl_mem   [POOL_ENTRIES];

    // read data registers
    logic [PW-1:0] head_rd_reg;
    logic [31:0]   key_rd_reg;
    logic [31:0]   val_rd_reg;
    logic [PW-1:0] next_rd_reg;
    logic [PW-1:0] prev_rd_reg;
    logic [IW-1:0] fl_rd_reg;

    // request and walk state
    chm_pkg::req_t    req_reg;
    logic [BUCKET_BITS-1:0] bucket_reg;
    logic [PW-1:0]    cur_reg;
    logic [PW-1:0]    head_reg;
    logic             found_reg;
    logic [IW-1:0]    e_reg;
    logic [PW-1:0]    nx_reg;
    logic [PW-1:0]    pv_reg;
    logic [31:0]      val_reg;
    logic [IW-1:0]    n_reg;
    logic [PW-1:0]    fc_reg;
    logic [PW-1:0]    lw_reg;
    logic [BUCKET_BITS-1:0] clr_reg;
    logic [1:0]       res_status_reg;
    logic [31:0]      res_value_reg;
    logic             out_valid_reg;
    chm_pkg::rsp_t    out_reg;

    logic [chm_pkg::KEY_HASH_BITS-1:0] hash_low;
    logic [chm_pkg::KEY_HASH_BITS-1:0] hash_mix;
    logic [BUCKET_BITS-1:0] in_bucket;
    logic [IW-1:0]    entry_addr;
    logic [PW-1:0]    pop_pos;
    logic             pop_fresh;
    logic [IW-1:0]    pop_idx;

    // bucket of the incoming key
    assign hash_low  = req_data.key[chm_pkg::KEY_HASH_BITS-1:0];
    assign hash_mix  = hash_low ^ (hash_low >> chm_pkg::HASH_SHIFT);
    assign in_bucket = hash_mix[BUCKET_BITS-1:0];

    assign entry_addr = cmd.take_head ? head_rd_reg[IW-1:0] : next_rd_reg[IW-1:0];

    // free stack top; slots below the low-water mark still hold their reset order
    assign pop_pos   = fc_reg - PW'(1);
    assign pop_fresh = (pop_pos < lw_reg);
    assign pop_idx   = pop_fresh ? (LAST_IDX - pop_pos[IW-1:0]) : fl_rd_reg;

    // bucket head table
    always_ff @(posedge clk)
    begin
        head_rd_reg <= head_mem[in_bucket];
        if (cmd.clear_step)
        begin
            head_mem[clr_reg] <= NIL;
        end
        else if (cmd.add_write)
        begin
            head_mem[bucket_reg] <= PW'(pop_idx);
        end
        else if (cmd.rem_write && (pv_reg == NIL))
        begin
            head_mem[bucket_reg] <= nx_reg;
        end
    end

    // entry keys and values
    always_ff @(posedge clk)
    begin
        key_rd_reg <= key_mem[entry_addr];
        val_rd_reg <= val_mem[entry_addr];
        if (cmd.add_write)
        begin
            key_mem[pop_idx] <= req_reg.key;
            val_mem[pop_idx] <= req_reg.value;
        end
    end

    // forward links
    always_ff @(posedge clk)
    begin
        next_rd_reg <= next_mem[entry_addr];
        if (cmd.add_write)
        begin
            next_mem[pop_idx] <= head_reg;
        end
        else if (cmd.rem_write && (pv_reg != NIL))
        begin
            next_mem[pv_reg[IW-1:0]] <= nx_reg;
        end
    end

    // backward links
    always_ff @(posedge clk)
    begin
        prev_rd_reg <= prev_mem[entry_addr];
        if (cmd.add_write)
        begin
            prev_mem[pop_idx] <= NIL;
        end
        else if (cmd.add_link)
        begin
            prev_mem[head_reg[IW-1:0]] <= PW'(n_reg);
        end
        else if (cmd.rem_write && (nx_reg != NIL))
        begin
            prev_mem[nx_reg[IW-1:0]] <= pv_reg;
        end
    end

    // free stack
    always_ff @(posedge clk)
    begin
        fl_rd_reg <= fl_mem[pop_pos[IW-1:0]];
        if (cmd.rem_write)
        begin
            fl_mem[fc_reg[IW-1:0]] <= e_reg;
        end
    end

    // payload registers of the current item
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            req_reg    <= req_data;
            bucket_reg <= in_bucket;
        end
        if (cmd.take_head)
        begin
            cur_reg  <= head_rd_reg;
            head_reg <= head_rd_reg;
        end
        else if (cmd.probe_next)
        begin
            cur_reg <= next_rd_reg;
        end
        if (cmd.record_found)
        begin
            e_reg   <= cur_reg[IW-1:0];
            nx_reg  <= next_rd_reg;
            pv_reg  <= prev_rd_reg;
            val_reg <= val_rd_reg;
        end
        if (cmd.add_write)
        begin
            n_reg <= pop_idx;
        end
        if (cmd.set_result)
        begin
            res_status_reg <= cmd.status_code;
            res_value_reg  <= cmd.use_val ? val_reg : not_found_value;
        end
        if (cmd.load_out)
        begin
            out_reg.status     <= res_status_reg;
            out_reg.read_value <= res_value_reg;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            found_reg     <= 1'b0;
            fc_reg        <= PW'(POOL_ENTRIES);
            lw_reg        <= PW'(POOL_ENTRIES);
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.accept)
            begin
                found_reg <= 1'b0;
            end
            else if (cmd.record_found)
            begin
                found_reg <= 1'b1;
            end
            if (cmd.clear_step)
            begin
                clr_reg <= clr_reg + BUCKET_BITS'(1);
            end
            if (cmd.add_write)
            begin
                fc_reg <= pop_pos;
                if (pop_fresh)
                begin
                    lw_reg <= pop_pos;
                end
            end
            else if (cmd.rem_write)
            begin
                fc_reg <= fc_reg + PW'(1);
            end
            if (cmd.load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // status to the controller
    always_comb
    begin
        sts.operation    = req_reg.operation;
        sts.head_nil     = (head_rd_reg == NIL);
        sts.head_was_nil = (head_reg == NIL);
        sts.key_hit      = (key_rd_reg == req_reg.key);
        sts.next_nil     = (next_rd_reg == NIL);
        sts.found        = found_reg;
        sts.pool_empty   = (fc_reg == '0);
        sts.out_free     = !out_valid_reg || rsp_ready;
        sts.clear_done   = (clr_reg == {BUCKET_BITS{1'b1}});
    end

    assign rsp_valid = out_valid_reg;
    assign rsp_data  = out_reg;

endmodule
